@@ sv/bgh_pkg.sv @@
// Shared types, constants and helpers for the letter bigram histogram.
package bgh_pkg;

  localparam int unsigned ALPHABET_SIZE_DEF = 26;
  localparam int unsigned COUNT_WIDTH_DEF   = 16;
  localparam int unsigned LETTER_W          = 5;
  localparam int unsigned PAIR_W            = 16;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  typedef enum logic [1:0] {
    REQ_CHAR  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INC,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [4:0] read_col;
  } req_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_count;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] idx;
  } letter_t;

  typedef struct packed {
    op_e  op;
    logic zero;
  } cmd_t;

  function automatic letter_t letter_decode(input logic [7:0] code);
    letter_t r;
    r.valid = 1'b0;
    r.idx   = '0;
    if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      r.valid = 1'b1;
      r.idx   = LETTER_W'(code - CHAR_LOWER_A);
    end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      r.valid = 1'b1;
      r.idx   = LETTER_W'(code - CHAR_UPPER_A);
    end
    return r;
  endfunction

endpackage

@@ sv/bgh_stream_if.sv @@
// Valid/ready stream interface carrying one payload item.
interface bgh_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/bgh_decode.sv @@
// Request decode, previous-letter tracking and table address generation.
module bgh_decode #(
  parameter int unsigned ALPHABET_SIZE = bgh_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned AW            = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  bgh_pkg::req_t   req_i,
  output bgh_pkg::cmd_t   cmd_o,
  output logic [AW-1:0]   addr_o
);

  logic [bgh_pkg::LETTER_W-1:0] prev_q, prev_d;
  logic                         prev_ok_q, prev_ok_d;
  bgh_pkg::letter_t             cur;
  logic                         cur_ok;
  logic                         rc_ok;

  always_comb begin
    cur    = bgh_pkg::letter_decode(req_i.char_code);
    cur_ok = cur.valid && (int'(cur.idx) < int'(ALPHABET_SIZE));
    rc_ok  = (int'(req_i.read_row) < int'(ALPHABET_SIZE)) &&
             (int'(req_i.read_col) < int'(ALPHABET_SIZE));
  end

  always_comb begin
    cmd_o.op   = bgh_pkg::OP_NONE;
    cmd_o.zero = 1'b0;
    addr_o     = AW'(prev_q) * AW'(ALPHABET_SIZE) + AW'(cur.idx);
    unique case (req_i.req_type)
      bgh_pkg::REQ_CHAR: begin
        cmd_o.op = (cur_ok && prev_ok_q) ? bgh_pkg::OP_INC : bgh_pkg::OP_NONE;
      end
      bgh_pkg::REQ_READ: begin
        cmd_o.op   = bgh_pkg::OP_READ;
        cmd_o.zero = !rc_ok;
        addr_o     = AW'(req_i.read_row) * AW'(ALPHABET_SIZE) + AW'(req_i.read_col);
      end
      bgh_pkg::REQ_CLEAR: begin
        cmd_o.op = bgh_pkg::OP_CLEAR;
      end
      default: begin
        cmd_o.op = bgh_pkg::OP_NONE;
      end
    endcase
  end

  always_comb begin
    prev_d    = prev_q;
    prev_ok_d = prev_ok_q;
    if (acc_i) begin
      unique case (req_i.req_type)
        bgh_pkg::REQ_CHAR: begin
          prev_ok_d = cur_ok;
          if (cur_ok) begin
            prev_d = cur.idx;
          end
        end
        bgh_pkg::REQ_CLEAR: begin
          prev_ok_d = 1'b0;
          prev_d    = '0;
        end
        default: begin
          prev_d    = prev_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      prev_ok_q <= 1'b0;
    end else begin
      prev_q    <= prev_d;
      prev_ok_q <= prev_ok_d;
    end
  end

endmodule

@@ sv/bgh_table.sv @@
// Counter memory with read-modify-write, write forwarding and clearing sweep.
module bgh_table #(
  parameter int unsigned ALPHABET_SIZE = bgh_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned COUNT_WIDTH   = bgh_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned AW            = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  bgh_pkg::cmd_t              cmd_i,
  input  logic [AW-1:0]              addr_i,
  output logic                       busy_o,
  output logic                       s1_read_o,
  output logic                       res_valid_o,
  output logic [bgh_pkg::PAIR_W-1:0] res_count_o
);

  localparam int unsigned DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic                   s1_valid_q;
  bgh_pkg::cmd_t          s1_cmd_q;
  logic [AW-1:0]          s1_addr_q;

  logic                   fwd_valid_q;
  logic [AW-1:0]          fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  logic                   clr_busy_q, clr_busy_d;
  logic [AW-1:0]          clr_cnt_q, clr_cnt_d;

  logic                   inc_en;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [bgh_pkg::PAIR_W-1:0] sat_count;

  always_comb begin
    cur      = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rdata_q;
    inc_data = (cur == CNT_MAX) ? cur : cur + COUNT_WIDTH'(1);
    inc_en   = s1_valid_q && s1_cmd_q.op == bgh_pkg::OP_INC;
    wr_en    = clr_busy_q || inc_en;
    wr_addr  = clr_busy_q ? clr_cnt_q : s1_addr_q;
    wr_data  = clr_busy_q ? '0 : inc_data;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= wr_addr;
    fwd_data_q <= wr_data;
    s1_addr_q  <= addr_i;
    s1_cmd_q   <= cmd_i;
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == LAST_ADDR) begin
        clr_busy_d = 1'b0;
        clr_cnt_d  = '0;
      end
    end else if (s1_valid_q && s1_cmd_q.op == bgh_pkg::OP_CLEAR) begin
      clr_busy_d = 1'b1;
      clr_cnt_d  = '0;
    end
  end

  // Reset starts a sweep so the table reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      s1_valid_q  <= acc_i;
      fwd_valid_q <= inc_en && !clr_busy_q;
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  generate
    if (COUNT_WIDTH > bgh_pkg::PAIR_W) begin : g_sat
      assign sat_count = (|cur[COUNT_WIDTH-1:bgh_pkg::PAIR_W]) ?
                         {bgh_pkg::PAIR_W{1'b1}} : cur[bgh_pkg::PAIR_W-1:0];
    end else begin : g_ext
      assign sat_count = bgh_pkg::PAIR_W'(cur);
    end
  endgenerate

  assign s1_read_o   = s1_valid_q && s1_cmd_q.op == bgh_pkg::OP_READ;
  assign res_valid_o = s1_read_o;
  assign res_count_o = s1_cmd_q.zero ? '0 : sat_count;
  assign busy_o      = clr_busy_q || (s1_valid_q && s1_cmd_q.op == bgh_pkg::OP_CLEAR);

endmodule

@@ sv/bgh_outbuf.sv @@
// Two-entry result buffer in front of the output channel.
module bgh_outbuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [bgh_pkg::PAIR_W-1:0] data_i,
  output logic [1:0]                 count_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [bgh_pkg::PAIR_W-1:0] data_o
);

  logic [bgh_pkg::PAIR_W-1:0] buf_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 count_q, count_d;
  logic                       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = count_q != 2'd0;
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

@@ sv/letter_bigram_histogram_top.sv @@
// Top level of the letter bigram histogram.
//
//  channel | dir | payload                                     | accepted when
//  req_i   | in  | req_type, char_code, read_row, read_col     | valid && ready
//  rsp_o   | out | pair_count (read items only)                | valid && ready
//
// One item per cycle while input is not stalled: address in the accept cycle,
// registered memory read, increment and write back in the next, with forwarding
// of the last write. A clear item blocks input while the sweep zeroes one entry
// per cycle; reset starts the same sweep. Otherwise input stalls only when the
// two-entry result buffer could overflow.
module letter_bigram_histogram_top #(
  parameter int unsigned ALPHABET_SIZE = bgh_pkg::ALPHABET_SIZE_DEF,
  parameter int unsigned COUNT_WIDTH   = bgh_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bgh_stream_if.sink   req_i,
  bgh_stream_if.source rsp_o
);

  localparam int unsigned AW = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);

  bgh_pkg::req_t              req;
  bgh_pkg::cmd_t              cmd;
  logic [AW-1:0]              addr;
  logic                       acc;
  logic                       busy;
  logic                       s1_read;
  logic                       res_valid;
  logic [bgh_pkg::PAIR_W-1:0] res_count;
  logic [1:0]                 buf_count;
  logic [bgh_pkg::PAIR_W-1:0] out_count;
  logic                       in_ready;

  assign req      = req_i.data;
  assign in_ready = !busy && ({1'b0, buf_count} + {2'b00, s1_read} < 3'd2);
  assign req_i.ready = in_ready;
  assign acc      = req_i.valid && in_ready;

  bgh_decode #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .AW            (AW)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .req_i  (req),
    .cmd_o  (cmd),
    .addr_o (addr)
  );

  bgh_table #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .AW            (AW)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .busy_o      (busy),
    .s1_read_o   (s1_read),
    .res_valid_o (res_valid),
    .res_count_o (res_count)
  );

  bgh_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_count),
    .count_o (buf_count),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (out_count)
  );

  assign rsp_o.data.pair_count = out_count;

endmodule

@@ sv/bgh_checker.sv @@
// Port-level assertions for the letter bigram histogram, bound to the top level.
module bgh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic [1:0]                 req_type_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [bgh_pkg::PAIR_W-1:0] pair_count_i
);

  logic req_acc;
  logic read_acc;
  assign req_acc  = req_valid_i && req_ready_i;
  assign read_acc = req_acc && req_type_i == bgh_pkg::REQ_READ;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(pair_count_i))
    else $error("result dropped or changed under stall");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && req_type_i == bgh_pkg::REQ_CLEAR |=> !req_ready_i)
    else $error("input taken right after a clear item");

  a_rsp_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_acc && req_type_i == bgh_pkg::REQ_READ, 2))
    else $error("result without a read item");

  a_no_rsp_for_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i && !read_acc && !$past(read_acc)
      |=> ##1 !rsp_valid_i)
    else $error("result appeared without a read item");

endmodule

bind letter_bigram_histogram_top bgh_checker u_bgh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.data.req_type),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .pair_count_i (rsp_o.data.pair_count)
);
